FILE: src/pdcs_pkg.sv
// Shared constants, codes and helper functions for the source capability selector.
package pdcs_pkg;

	// table geometry
	localparam int NUM_ENTRIES    = 13;
	localparam int EXTENDED_START = 7;
	localparam int ADDR_W         = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

	// field widths
	localparam int CMD_W   = 1;
	localparam int INDEX_W = 4;
	localparam int WORD_W  = 16;
	localparam int TV_W    = 13;
	localparam int TC_W    = 10;
	localparam int NUM_W   = 4;
	localparam int VSEL_W  = 8;
	localparam int CSEL_W  = 4;

	// configuration port
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_LIMIT_CURRENT = 1'b0;

	// request commands
	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD    = 1'b0,
		CMD_REQUEST = 1'b1
	} cmd_t;

	// voltage steps and minimum voltages, 10 mV units
	localparam logic [13:0] STEP_STD  = 14'd10;
	localparam logic [13:0] STEP_EXT  = 14'd20;
	localparam logic [13:0] VMIN_STD  = 14'd330;
	localparam logic [13:0] VMIN_EXT  = 14'd1500;

	// reciprocal of ten: x * RECIP10 >> RECIP10_SH is exact for 13-bit x
	localparam logic [15:0] RECIP10    = 16'd52429;
	localparam int          RECIP10_SH = 19;

	// smallest (target - 100) that gives current code k+1
	localparam logic [8:0] LIMIT_THR [15] = '{
		9'd14,  9'd40,  9'd67,  9'd94,  9'd120,
		9'd147, 9'd174, 9'd200, 9'd227, 9'd254,
		9'd280, 9'd307, 9'd334, 9'd360, 9'd387
	};

	// maximum current of an entry's current code, 10 mA units
	function automatic logic [9:0] entry_imax(input logic [CSEL_W-1:0] code);
		logic [9:0] imax;
		case (code)
			4'd0:    imax = 10'd125;
			4'd15:   imax = 10'd500;
			default: imax = 10'd125 + 10'(code) * 10'd25;
		endcase
		return imax;
	endfunction

	// current code derived from the target current
	function automatic logic [CSEL_W-1:0] limited_code(input logic [TC_W-1:0] tc);
		logic [CSEL_W-1:0] code;
		logic [8:0]        d;
		d    = 9'(tc - 10'd100);
		code = '0;
		if (tc >= 10'd500) begin
			code = 4'd15;
		end else if (tc > 10'd100) begin
			for (int k = 0; k < 15; k++) begin
				if (d >= LIMIT_THR[k]) begin
					code = 4'(k + 1);
				end
			end
		end
		return code;
	endfunction

endpackage

FILE: src/pdcs_if.sv
// Request and result channel interfaces of the source capability selector.
interface pdcs_req_if;
	logic                             valid;
	logic                             ready;
	logic [pdcs_pkg::CMD_W-1:0]       command;
	logic [pdcs_pkg::INDEX_W-1:0]     entry_index;
	logic [pdcs_pkg::WORD_W-1:0]      capability_word;
	logic [pdcs_pkg::TV_W-1:0]        req_voltage;
	logic [pdcs_pkg::TC_W-1:0]        req_current;
	logic                             current_given;

	modport source (
		output valid, command, entry_index, capability_word,
		       req_voltage, req_current, current_given,
		input  ready
	);
	modport sink (
		input  valid, command, entry_index, capability_word,
		       req_voltage, req_current, current_given,
		output ready
	);
endinterface

interface pdcs_rsp_if;
	logic                             valid;
	logic                             ready;
	logic                             found;
	logic [pdcs_pkg::NUM_W-1:0]       entry_number;
	logic [pdcs_pkg::VSEL_W-1:0]      voltage_select;
	logic [pdcs_pkg::CSEL_W-1:0]      current_select;
	logic [pdcs_pkg::WORD_W-1:0]      request_word;

	modport source (
		output valid, found, entry_number, voltage_select, current_select, request_word,
		input  ready
	);
	modport sink (
		input  valid, found, entry_number, voltage_select, current_select, request_word,
		output ready
	);
endinterface

FILE: src/pdcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pdcs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: src/pd_source_capability_selector.sv
// Top level: capability table, request scan sequencer and result register.
// A load writes the table on acceptance; the next request is accepted the following cycle.
// A scan request reads the table from entry 0 in order and stops at the first match or
// after the last entry; its result goes via the result register to the output register,
// which must be free first; then a new request is accepted. Reset clears the per-entry
// valid bits (table reads as all zero, nothing detected) and the current limit register.
module pd_source_capability_selector (
	input  logic                               clk,
	input  logic                               arst_n,
	pdcs_req_if.sink                           req,
	pdcs_rsp_if.source                         rsp,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [pdcs_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [pdcs_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [pdcs_pkg::APB_DATA_W-1:0]    prdata,
	output logic                               pready
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	localparam logic [pdcs_pkg::ADDR_W-1:0] LAST_ADDR =
		pdcs_pkg::ADDR_W'(pdcs_pkg::NUM_ENTRIES - 1);

	state_t state_q;

	// configuration register
	logic limit_q;
	logic cfg_hit;

	assign pready  = 1'b1;
	assign cfg_hit = (paddr[2] == pdcs_pkg::REG_LIMIT_CURRENT);
	assign prdata  = cfg_hit ? {{(pdcs_pkg::APB_DATA_W-1){1'b0}}, limit_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && cfg_hit) begin
			limit_q <= pwdata[0];
		end
	end

	// input handshake
	logic req_fire;
	logic load_fire;
	logic scan_fire;
	logic idx_ok;

	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign idx_ok    = ({1'b0, req.entry_index} < 5'(pdcs_pkg::NUM_ENTRIES));
	assign load_fire = req_fire && (req.command == pdcs_pkg::CMD_LOAD) && idx_ok;
	assign scan_fire = req_fire && (req.command == pdcs_pkg::CMD_REQUEST);

	// capability table and valid bits
	logic [pdcs_pkg::ADDR_W-1:0]        rd_addr_q;
	logic [pdcs_pkg::WORD_W-1:0]        rdata;
	logic [pdcs_pkg::NUM_ENTRIES-1:0]   valid_q;

	pdcs_ram #(
		.WIDTH (pdcs_pkg::WORD_W),
		.DEPTH (pdcs_pkg::NUM_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (load_fire),
		.waddr (req.entry_index[pdcs_pkg::ADDR_W-1:0]),
		.wdata (req.capability_word),
		.raddr (rd_addr_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (load_fire) begin
			valid_q[req.entry_index[pdcs_pkg::ADDR_W-1:0]] <= 1'b1;
		end
	end

	// request operands, with division and current limit worked out at acceptance
	logic [pdcs_pkg::TV_W-1:0]   tv_q;
	logic [pdcs_pkg::TC_W-1:0]   tc_q;
	logic                        given_q;
	logic [pdcs_pkg::VSEL_W-1:0] vsel10_q;
	logic [pdcs_pkg::VSEL_W-1:0] vsel20_q;
	logic [pdcs_pkg::CSEL_W-1:0] lim_q;
	logic [28:0]                 div_prod;
	logic [9:0]                  div10;
	logic [9:0]                  div20;

	assign div_prod = 29'(req.req_voltage) * 29'(pdcs_pkg::RECIP10);
	assign div10    = div_prod[pdcs_pkg::RECIP10_SH +: 10];
	assign div20    = div10 >> 1;

	always_ff @(posedge clk) begin
		if (scan_fire) begin
			tv_q     <= req.req_voltage;
			tc_q     <= req.req_current;
			given_q  <= req.current_given;
			vsel10_q <= (div10 > 10'd255) ? 8'hFF : div10[7:0];
			vsel20_q <= (div20 > 10'd255) ? 8'hFF : div20[7:0];
			lim_q    <= pdcs_pkg::limited_code(req.req_current);
		end
	end

	// entry evaluation on the word just read
	logic                        eval_valid_s1;
	logic [pdcs_pkg::ADDR_W-1:0] idx_s1;
	logic [pdcs_pkg::WORD_W-1:0] w;
	logic                        ext;
	logic [13:0]                 step;
	logic [13:0]                 vmax;
	logic [13:0]                 vmin;
	logic [13:0]                 tv14;
	logic                        fixed_match;
	logic                        var_match;
	logic                        cur_ok;
	logic                        hit;
	logic [4:0]                  num_full;
	logic [pdcs_pkg::VSEL_W-1:0] vsel;
	logic [pdcs_pkg::CSEL_W-1:0] csel;

	always_comb begin
		w    = valid_q[idx_s1] ? rdata : '0;
		ext  = (5'(idx_s1) >= 5'(pdcs_pkg::EXTENDED_START));
		step = ext ? pdcs_pkg::STEP_EXT : pdcs_pkg::STEP_STD;
		vmax = 14'(w[7:0]) * step;
		tv14 = 14'(tv_q);
		vmin = '0;
		if (w[9:8] == 2'd1 || w[9:8] == 2'd2) begin
			vmin = ext ? pdcs_pkg::VMIN_EXT : pdcs_pkg::VMIN_STD;
		end
		fixed_match = (vmax <= tv14 + step) && (tv14 <= vmax + step);
		var_match   = (tv14 + 14'd1 >= vmin) && (tv14 <= vmax + 14'd1);
		cur_ok      = !given_q ||
			(11'(pdcs_pkg::entry_imax(w[13:10])) + 11'd1 >= 11'(tc_q));
		hit         = w[15] && (w[14] ? var_match : fixed_match) && cur_ok;
		num_full    = 5'(idx_s1) + 5'd1;
		vsel        = w[14] ? (ext ? vsel20_q : vsel10_q) : 8'hFF;
		csel        = (limit_q && given_q && (lim_q < w[13:10])) ? lim_q : w[13:10];
	end

	// scan sequencer
	logic                        issue_q;
	logic                        res_found_q;
	logic [pdcs_pkg::NUM_W-1:0]  res_num_q;
	logic [pdcs_pkg::VSEL_W-1:0] res_vsel_q;
	logic [pdcs_pkg::CSEL_W-1:0] res_csel_q;
	logic                        out_valid_q;
	logic                        out_free;

	assign out_free = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			issue_q       <= 1'b0;
			eval_valid_s1 <= 1'b0;
			rd_addr_q     <= '0;
			idx_s1        <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (scan_fire) begin
						state_q       <= ST_SCAN;
						rd_addr_q     <= '0;
						issue_q       <= 1'b1;
						eval_valid_s1 <= 1'b0;
					end
				end
				ST_SCAN: begin
					eval_valid_s1 <= issue_q;
					idx_s1        <= rd_addr_q;
					if (issue_q) begin
						if (rd_addr_q == LAST_ADDR) begin
							issue_q <= 1'b0;
						end else begin
							rd_addr_q <= rd_addr_q + pdcs_pkg::ADDR_W'(1);
						end
					end
					if (eval_valid_s1 && (hit || idx_s1 == LAST_ADDR)) begin
						state_q       <= ST_FINISH;
						issue_q       <= 1'b0;
						eval_valid_s1 <= 1'b0;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// scan result, all zero on a miss
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && eval_valid_s1 && (hit || idx_s1 == LAST_ADDR)) begin
			res_found_q <= hit;
			res_num_q   <= hit ? num_full[3:0] : '0;
			res_vsel_q  <= hit ? vsel : '0;
			res_csel_q  <= hit ? csel : '0;
		end
	end

	// output register
	logic                        load_out;
	logic                        o_found_q;
	logic [pdcs_pkg::NUM_W-1:0]  o_num_q;
	logic [pdcs_pkg::VSEL_W-1:0] o_vsel_q;
	logic [pdcs_pkg::CSEL_W-1:0] o_csel_q;

	assign load_out = (state_q == ST_FINISH) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			o_found_q <= res_found_q;
			o_num_q   <= res_num_q;
			o_vsel_q  <= res_vsel_q;
			o_csel_q  <= res_csel_q;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.found          = o_found_q;
	assign rsp.entry_number   = o_num_q;
	assign rsp.voltage_select = o_vsel_q;
	assign rsp.current_select = o_csel_q;
	assign rsp.request_word   = {o_num_q, o_csel_q, o_vsel_q};

endmodule
